@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Types, widths and codes shared by the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // List capacity and derived widths
  localparam int LIST_DEPTH = 16;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Fixed field widths
  localparam int VALUE_W    = 32;
  localparam int KIND_W     = 3;
  localparam int POS_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int COUNT_O_W  = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Request kinds
  localparam logic [KIND_W-1:0] K_INSERT_AT   = 3'd0;
  localparam logic [KIND_W-1:0] K_APPEND      = 3'd1;
  localparam logic [KIND_W-1:0] K_REMOVE_AT   = 3'd2;
  localparam logic [KIND_W-1:0] K_REMOVE_LAST = 3'd3;
  localparam logic [KIND_W-1:0] K_READ_AT     = 3'd4;
  localparam logic [KIND_W-1:0] K_READ_LAST   = 3'd5;
  localparam logic [KIND_W-1:0] K_WRITE_AT    = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // One result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_O_W-1:0]      entry_count;
  } result_t;

  // Entry store access command
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_cmd_t;

endpackage

@@ rtl/core/ple_if.sv @@
// ----------------------------------------------------------------------------
// ple_if
// Valid/ready channels for requests and results of the list engine.
// ----------------------------------------------------------------------------

// Request channel
interface ple_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [ple_pkg::KIND_W-1:0]           kind;
  logic [ple_pkg::POS_W-1:0]            position;
  logic signed [ple_pkg::VALUE_W-1:0]   item_value;

  modport source (output valid, output kind, output position, output item_value,
                  input ready);
  modport sink   (input valid, input kind, input position, input item_value,
                  output ready);
endinterface

// Result channel
interface ple_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ple_pkg::VALUE_W-1:0]   result_value;
  logic [ple_pkg::STATUS_W-1:0]         status;
  logic [ple_pkg::COUNT_O_W-1:0]        entry_count;

  modport source (output valid, output result_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input result_value, input status,
                  input entry_count, output ready);
endinterface

@@ rtl/core/ple_ram.sv @@
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: checks a request, then moves entries one at a time
// through the entry RAM with a shared index step and compare unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ple_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  ple_req_if.sink                       req,
  output ple_pkg::ram_cmd_t             ram,
  input  logic [ple_pkg::VALUE_W-1:0]   rdata,
  output logic                          push,
  output ple_pkg::result_t              result,
  input  logic                          can_take
);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_WR  = 4'd2;
  localparam logic [3:0] S_PUT     = 4'd3;
  localparam logic [3:0] S_GET_RD  = 4'd4;
  localparam logic [3:0] S_GET_CAP = 4'd5;
  localparam logic [3:0] S_DEL_RD  = 4'd6;
  localparam logic [3:0] S_DEL_WR  = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]                     state;
  logic [ple_pkg::CNT_W-1:0]      count;
  logic [ple_pkg::KIND_W-1:0]     op;
  logic [ple_pkg::ADDR_W-1:0]     idx;
  logic [ple_pkg::ADDR_W-1:0]     at;
  logic [ple_pkg::ADDR_W-1:0]     lim;
  logic [ple_pkg::VALUE_W-1:0]    val;
  logic [ple_pkg::VALUE_W-1:0]    res;
  logic [ple_pkg::STATUS_W-1:0]   st;

  logic                           accept;
  logic [ple_pkg::CMP_W-1:0]      pos_x;
  logic [ple_pkg::CMP_W-1:0]      cnt_x;
  logic [ple_pkg::ADDR_W-1:0]     pos_lo;
  logic [ple_pkg::ADDR_W-1:0]     cnt_lo;
  logic [ple_pkg::ADDR_W-1:0]     last_lo;
  logic [ple_pkg::STATUS_W-1:0]   chk;
  logic                           shift_down;
  logic [ple_pkg::ADDR_W-1:0]     step;
  logic [ple_pkg::ADDR_W-1:0]     cmp_a;
  logic                           more_del;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Operand views of position and count
  assign pos_x   = ple_pkg::CMP_W'(req.position);
  assign cnt_x   = ple_pkg::CMP_W'(count);
  assign pos_lo  = pos_x[ple_pkg::ADDR_W-1:0];
  assign cnt_lo  = count[ple_pkg::ADDR_W-1:0];
  assign last_lo = cnt_lo - 1'b1;

  // Check the request against the current count
  always_comb begin
    chk = ple_pkg::ST_OK;
    unique case (req.kind) inside
      ple_pkg::K_INSERT_AT: begin
        if (pos_x > cnt_x) begin
          chk = ple_pkg::ST_RANGE;
        end else if (count == ple_pkg::CNT_W'(ple_pkg::LIST_DEPTH)) begin
          chk = ple_pkg::ST_FULL;
        end
      end
      ple_pkg::K_APPEND: begin
        if (count == ple_pkg::CNT_W'(ple_pkg::LIST_DEPTH)) begin
          chk = ple_pkg::ST_FULL;
        end
      end
      ple_pkg::K_REMOVE_AT, ple_pkg::K_READ_AT, ple_pkg::K_WRITE_AT: begin
        if (count == '0) begin
          chk = ple_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          chk = ple_pkg::ST_RANGE;
        end
      end
      ple_pkg::K_REMOVE_LAST, ple_pkg::K_READ_LAST: begin
        if (count == '0) begin
          chk = ple_pkg::ST_EMPTY;
        end
      end
      default: chk = ple_pkg::ST_OK;
    endcase
  end

  // Shared index unit: one step and one compare against the removal limit
  assign shift_down = (state == S_INS_RD) || (state == S_INS_WR);
  assign step       = shift_down ? (idx - 1'b1) : (idx + 1'b1);
  assign cmp_a      = (state == S_GET_CAP) ? idx : step;
  assign more_del   = (cmp_a < lim);

  // Drive the entry RAM
  always_comb begin
    ram.we    = 1'b0;
    ram.waddr = idx;
    ram.wdata = rdata;
    ram.raddr = idx;
    unique case (state)
      S_INS_RD:  ram.raddr = step;
      S_INS_WR:  ram.we = 1'b1;
      S_PUT: begin
        ram.we    = 1'b1;
        ram.waddr = at;
        ram.wdata = val;
      end
      S_GET_CAP: begin
        ram.we    = (op == ple_pkg::K_WRITE_AT);
        ram.wdata = val;
      end
      S_DEL_RD:  ram.raddr = step;
      S_DEL_WR:  ram.we = 1'b1;
      default:   ram.we = 1'b0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= req.kind;
            val <= req.item_value;
            st  <= chk;
            res <= '0;
            lim <= last_lo;
            if (chk != ple_pkg::ST_OK) begin
              state <= S_DONE;
            end else begin
              unique case (req.kind) inside
                ple_pkg::K_INSERT_AT, ple_pkg::K_APPEND: begin
                  idx <= cnt_lo;
                  at  <= (req.kind == ple_pkg::K_APPEND) ? cnt_lo : pos_lo;
                  if (((req.kind == ple_pkg::K_APPEND) ? cnt_lo : pos_lo) == cnt_lo) begin
                    state <= S_PUT;
                  end else begin
                    state <= S_INS_RD;
                  end
                end
                ple_pkg::K_REMOVE_AT, ple_pkg::K_READ_AT, ple_pkg::K_WRITE_AT: begin
                  idx   <= pos_lo;
                  state <= S_GET_RD;
                end
                ple_pkg::K_REMOVE_LAST, ple_pkg::K_READ_LAST: begin
                  idx   <= last_lo;
                  state <= S_GET_RD;
                end
                default: state <= S_DONE;
              endcase
            end
          end
        end
        // Open a slot: move entry idx-1 up to idx
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          idx <= step;
          if (step == at) begin
            state <= S_PUT;
          end else begin
            state <= S_INS_RD;
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        // Fetch the addressed entry
        S_GET_RD: state <= S_GET_CAP;
        S_GET_CAP: begin
          res <= rdata;
          if ((op == ple_pkg::K_REMOVE_AT) || (op == ple_pkg::K_REMOVE_LAST)) begin
            if (more_del) begin
              state <= S_DEL_RD;
            end else begin
              count <= count - 1'b1;
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        // Close the gap: move entry idx+1 down to idx
        S_DEL_RD: state <= S_DEL_WR;
        S_DEL_WR: begin
          idx <= step;
          if (more_del) begin
            state <= S_DEL_RD;
          end else begin
            count <= count - 1'b1;
            state <= S_DONE;
          end
        end
        // Hand the result to the output stage
        S_DONE: begin
          if (can_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result to the output stage
  assign push                = (state == S_DONE) && can_take;
  assign result.result_value = res;
  assign result.status       = st;
  assign result.entry_count  = cnt_x[ple_pkg::COUNT_O_W-1:0];

  `ASSERT_ALWAYS(a_count_bound, count <= ple_pkg::CNT_W'(ple_pkg::LIST_DEPTH), "count above depth")
  `ASSERT_NEXT(a_put_grows, state == S_PUT, count == ple_pkg::CNT_W'($past(count) + 1'b1), "insert did not grow count")
  `ASSERT_SAME(a_ins_above, state == S_INS_WR, idx > at, "insert shift passed its slot")
  `ASSERT_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted request left sequencer idle")
  `ASSERT_SAME(a_fail_direct, (state == S_DONE) && (st != ple_pkg::ST_OK), res == '0, "failed request carries a value")

endmodule

@@ rtl/core/ple_out.sv @@
// ----------------------------------------------------------------------------
// ple_out
// Output register for result items; frees the sequencer while a result waits.
// ----------------------------------------------------------------------------
module ple_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ple_pkg::result_t result,
  output logic             can_take,
  ple_rsp_if.source        rsp
);

  logic             valid;
  ple_pkg::result_t data;

  // Load when empty or when the held result transfers this cycle
  assign can_take = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_take) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= result;
    end
  end

  assign rsp.valid        = valid;
  assign rsp.result_value = data.result_value;
  assign rsp.status       = data.status;
  assign rsp.entry_count  = data.entry_count;

endmodule

@@ rtl/core/positional_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of signed 32-bit values with positional insert/remove.
// ----------------------------------------------------------------------------
// One request is taken at a time; req.ready is high only while the sequencer
// is idle. The entries live in a single RAM with one write and one registered
// read port, and every insert or remove shifts the later entries one place at
// a time through that port, each move a read state and then a write state. An
// insert shifts from the end down to its position, then writes the new value;
// remove, read and write read the addressed entry and capture it, a write also
// stores the new value there and a remove then shifts the later entries down.
// Failed or unused-kind requests go straight to the done state. The sequencer
// waits in its done state for as long as the result register still holds an
// earlier result that rsp has not taken. A result register on rsp lets the
// next request in while the last result waits. No clearing pass after reset.
module positional_list_engine_top (
  input  logic       clk,
  input  logic       rst,
  ple_req_if.sink    req,
  ple_rsp_if.source  rsp
);

  ple_pkg::ram_cmd_t           ram;
  logic [ple_pkg::VALUE_W-1:0] rdata;
  logic                        push;
  logic                        can_take;
  ple_pkg::result_t            result;

  // Entry store
  ple_ram #(
    .WIDTH (ple_pkg::VALUE_W),
    .DEPTH (ple_pkg::LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // Request sequencer
  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .ram      (ram),
    .rdata    (rdata),
    .push     (push),
    .result   (result),
    .can_take (can_take)
  );

  // Result register
  ple_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .result   (result),
    .can_take (can_take),
    .rsp      (rsp)
  );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_list_engine_top. A queue of requests,
// built up front from a short directed run and a long random run, feeds a
// clocked driver on the request channel. Each request transfer updates a
// shadow copy of the list and queues the expected result. A clocked monitor
// checks each result transfer field by field. Both channels idle and stall
// at random, in phases of varying pressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int RANDOM_REQUESTS = 1950;
  localparam int NUM_PHASES      = 4;
  localparam int SETTLE_CYCLES   = 20;
  localparam int STALL_LIMIT     = 3000;

  // Percent of cycles the sender idles / the receiver stalls, per phase
  localparam int SEND_IDLE_PCT[NUM_PHASES]  = '{0, 86, 0, 28};
  localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 86, 28};

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;
    int                        phase;
  } list_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ple_req_if req_ch();
  ple_rsp_if rsp_ch();

  positional_list_engine_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow list: entries and occupancy
  logic signed [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
  int                        shadow_len;

  list_req_t pending_requests[$];
  result_t   expected_results[$];
  list_req_t held_req;
  int        cur_phase;
  int        directed_count;
  int        accepted_count;
  int        checked_count;
  int        mismatch_count;
  int        status_seen[4];
  int        quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the shadow list and return what the block must answer
  function automatic result_t apply_request(input list_req_t r);
    result_t res;
    int      at;
    bit      positional;
    res.result_value = '0;
    res.status       = ST_OK;
    case (r.kind)
      K_INSERT_AT, K_APPEND: begin
        at = (r.kind == K_APPEND) ? shadow_len : int'(r.position);
        if (r.kind == K_INSERT_AT && int'(r.position) > shadow_len) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[at] = r.item_value;
          shadow_len++;
        end
      end
      K_REMOVE_AT, K_REMOVE_LAST, K_READ_AT, K_READ_LAST, K_WRITE_AT: begin
        positional = (r.kind == K_REMOVE_AT || r.kind == K_READ_AT ||
                      r.kind == K_WRITE_AT);
        // Empty list wins over a bad position
        if (shadow_len == 0) begin
          res.status = ST_EMPTY;
        end else if (positional && int'(r.position) >= shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          at = positional ? int'(r.position) : shadow_len - 1;
          res.result_value = shadow_entries[at];
          if (r.kind == K_REMOVE_AT || r.kind == K_REMOVE_LAST) begin
            for (int i = at; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
            shadow_len--;
          end else if (r.kind == K_WRITE_AT) begin
            shadow_entries[at] = r.item_value;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_O_W'(shadow_len);
    return res;
  endfunction

  // Queue a request; track list state while building so positions stay meaningful
  function automatic void queue_request(input logic [KIND_W-1:0] kind,
                                        input int pos,
                                        input logic signed [VALUE_W-1:0] value,
                                        input int phase);
    list_req_t r;
    result_t   unused;
    r.kind       = kind;
    r.position   = POS_W'(pos);
    r.item_value = value;
    r.phase      = phase;
    pending_requests.push_back(r);
    unused = apply_request(r);
  endfunction

  task automatic check_field(input string name, input logic signed [VALUE_W-1:0] exp_v,
                             input logic signed [VALUE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
               $time, checked_count, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Request driver: hold an item until its transfer, then load the next one
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_request(held_req));
        accepted_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() > 0 &&
            $urandom_range(0, 99) >= SEND_IDLE_PCT[pending_requests[0].phase]) begin
          held_req            = pending_requests.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.kind       <= held_req.kind;
          req_ch.position   <= held_req.position;
          req_ch.item_value <= held_req.item_value;
          cur_phase         <= held_req.phase;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, actual %0d/%0d/%0d",
                   $time, rsp_ch.result_value, rsp_ch.status, rsp_ch.entry_count);
          mismatch_count++;
        end else begin
          result_t exp_res;
          exp_res = expected_results.pop_front();
          check_field("result_value", exp_res.result_value, rsp_ch.result_value);
          check_field("status", exp_res.status, rsp_ch.status);
          check_field("entry_count", exp_res.entry_count, rsp_ch.entry_count);
          if (!$isunknown(rsp_ch.status)) status_seen[rsp_ch.status]++;
          checked_count++;
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= RECV_STALL_PCT[cur_phase]);
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("positional_list_engine_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned grow_w[7];
    int unsigned shrink_w[7];
    bit          growing;
    int          pick;
    int          acc;
    int          pos;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;

    grow_w   = '{30, 20, 8, 7, 12, 5, 18};
    shrink_w = '{8, 7, 30, 20, 12, 5, 18};

    // Known levels on every input before the first edge
    req_ch.valid      = 1'b0;
    req_ch.kind       = K_INSERT_AT;
    req_ch.position   = '0;
    req_ch.item_value = '0;
    rsp_ch.ready      = 1'b0;
    cur_phase         = 0;
    quiet_cycles      = 0;
    shadow_len        = 0;

    // Directed: empty list, range edges, value extremes, every kind
    queue_request(K_READ_LAST,   0,  32'sd0,         0);
    queue_request(K_REMOVE_AT,   16, 32'sd0,         0);
    queue_request(K_WRITE_AT,    5,  32'sd9,         0);
    queue_request(K_REMOVE_LAST, 0,  32'sd0,         0);
    queue_request(K_READ_AT,     0,  32'sd0,         0);
    queue_request(K_INSERT_AT,   1,  32'sd1,         0);
    queue_request(K_INSERT_AT,   0,  32'h7FFF_FFFF,  0);
    queue_request(K_APPEND,      0,  32'h8000_0000,  0);
    queue_request(K_INSERT_AT,   1,  -32'sd1,        0);
    queue_request(K_INSERT_AT,   3,  32'h5555_5555,  0);
    queue_request(K_INSERT_AT,   0,  32'hAAAA_AAAA,  0);
    queue_request(K_READ_AT,     4,  32'sd0,         0);
    queue_request(K_READ_AT,     5,  32'sd0,         0);
    queue_request(K_WRITE_AT,    0,  32'sd0,         0);
    queue_request(K_WRITE_AT,    16, 32'sd7,         0);
    queue_request(K_READ_LAST,   0,  32'sd0,         0);
    queue_request(K_REMOVE_AT,   1,  32'sd0,         0);
    queue_request(K_REMOVE_AT,   4,  32'sd0,         0);
    queue_request(K_REMOVE_LAST, 0,  32'sd0,         0);
    queue_request(K_READ_AT,     0,  32'sd0,         0);
    directed_count = pending_requests.size();

    // Random: swing between filling and draining so full and empty both recur
    growing = 1'b1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (growing && shadow_len == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (!growing && shadow_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      else if ($urandom_range(0, 59) == 0) growing = !growing;

      pick = $urandom_range(0, 99);
      acc  = 0;
      kind = K_WRITE_AT;
      for (int k = 0; k < 7; k++) begin
        acc += growing ? grow_w[k] : shrink_w[k];
        if (pick < acc) begin
          kind = KIND_W'(k);
          break;
        end
      end

      // Mostly legal positions, some anywhere from 0 to LIST_DEPTH
      if ($urandom_range(0, 99) < 15 || kind == K_APPEND || kind == K_REMOVE_LAST ||
          kind == K_READ_LAST) begin
        pos = $urandom_range(0, LIST_DEPTH);
      end else if (kind == K_INSERT_AT) begin
        pos = $urandom_range(0, shadow_len);
      end else begin
        pos = (shadow_len > 0) ? $urandom_range(0, shadow_len - 1) : 0;
      end

      case ($urandom_range(0, 9))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = 32'sd0;
        3:       value = -32'sd1;
        default: value = $urandom;
      endcase

      queue_request(kind, pos, value, (n * NUM_PHASES) / RANDOM_REQUESTS);
    end

    // Restart the shadow list for the run itself
    shadow_len = 0;

    wait (!rst);
    while (pending_requests.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived: expected %0d/%0d/%0d, actual none",
               $time, expected_results.size(), expected_results[0].result_value,
               expected_results[0].status, expected_results[0].entry_count);
      mismatch_count++;
    end

    $display("Checked %0d of %0d requests (%0d directed) across %0d idle/stall phases.",
             checked_count, accepted_count, directed_count, NUM_PHASES);
    $display("Status mix: ok %0d, bad position %0d, full %0d, empty %0d; mismatches %0d.",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
             status_seen[ST_EMPTY], mismatch_count);
    if (mismatch_count == 0) begin
      $display("positional_list_engine_top verification clean");
    end else begin
      $display("positional_list_engine_top verification failed");
    end
    $finish;
  end

  // Hold reset at the start, then release it
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ple_pkg.sv
rtl/core/ple_if.sv
rtl/core/ple_ram.sv
rtl/core/ple_ctrl.sv
rtl/core/ple_out.sv
rtl/core/positional_list_engine_top.sv
test/tb.sv
